// ===== hw/rtl/assert_macros.svh =====
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge out of reset.
`define PAL_ASSERT(lbl, clk, rst_n, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("assertion failed");

// Same-cycle implication.
`define PAL_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("implication failed");

// Next-cycle implication.
`define PAL_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle implication failed");

`endif

// ===== hw/rtl/pal_pkg.sv =====
// Package: sizes, codes and cell control type for the positional array list.
`timescale 1ns / 1ps

package pal_pkg;

    localparam int DEPTH  = 64;
    localparam int IDX_W  = $clog2(DEPTH);
    localparam int POS_W  = 7;
    localparam int CNT_W  = 7;
    localparam int DATA_W = 32;

    typedef enum logic [2:0] {
        ACT_PUSH_FRONT = 3'd0,
        ACT_PUSH_BACK  = 3'd1,
        ACT_INSERT     = 3'd2,
        ACT_ERASE_FRONT = 3'd3,
        ACT_ERASE_BACK = 3'd4,
        ACT_ERASE      = 3'd5,
        ACT_SEARCH     = 3'd6,
        ACT_NOP        = 3'd7
    } action_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2,
        ST_RANGE = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        OP_NONE = 2'd0,
        OP_INS  = 2'd1,
        OP_DEL  = 2'd2,
        OP_FIND = 2'd3
    } cell_op_t;

    typedef struct packed {
        cell_op_t           op;
        logic [IDX_W-1:0]   at;
        logic [DATA_W-1:0]  value;
        logic [CNT_W-1:0]   count;
    } cell_ctrl_t;

endpackage

// ===== hw/rtl/pal_cell.sv =====
// One list slot: shifts with its neighbors on insert/erase, compares on search.
`timescale 1ns / 1ps

module pal_cell import pal_pkg::*; (
    input  logic              aclk,
    input  logic [IDX_W-1:0]  cell_idx,
    input  cell_ctrl_t        ctrl,
    input  logic [DATA_W-1:0] left_data,
    input  logic [DATA_W-1:0] right_data,
    output logic [DATA_W-1:0] data,
    output logic              match
);

    logic [DATA_W-1:0] data_reg, data_next;
    logic              match_reg, match_next;
    logic              in_list;

    assign in_list = {1'b0, cell_idx} < CNT_W'(ctrl.count);

    always_comb begin
        data_next  = data_reg;
        match_next = match_reg;
        case (ctrl.op)
            OP_INS: begin
                if (cell_idx > ctrl.at) begin
                    data_next = left_data;
                end else if (cell_idx == ctrl.at) begin
                    data_next = ctrl.value;
                end
            end
            OP_DEL: begin
                if (cell_idx >= ctrl.at) begin
                    data_next = right_data;
                end
            end
            OP_FIND: begin
                match_next = in_list && (data_reg == ctrl.value);
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        data_reg  <= data_next;
        match_reg <= match_next;
    end

    assign data  = data_reg;
    assign match = match_reg;

endmodule

// ===== hw/rtl/pal_prio.sv =====
// Priority encoder: 1-based position of the highest set match bit, 0 if none.
`timescale 1ns / 1ps

module pal_prio import pal_pkg::*; (
    input  logic [DEPTH-1:0] match,
    output logic [CNT_W-1:0] found
);

    always_comb begin
        found = '0;
        for (int i = 0; i < DEPTH; i++) begin
            if (match[i]) begin
                found = CNT_W'(i + 1);
            end
        end
    end

endmodule

// ===== hw/rtl/positional_array_list_core.sv =====
// Top level: request decode, row of list cells, match encoder and result register.
//
//   channel | direction | ports
//   --------+-----------+-------------------------------------------------
//   s_      | in        | s_valid s_ready s_action s_position s_value
//   m_      | out       | m_valid m_ready m_status m_found_position m_count
//
// The cells shift or compare in the cycle a request is accepted; in S_FIND the
// match vector is encoded and the result registered once m_ is free.
// A new request is taken while a finished result still waits on m_.
// The search stage holds while the result register is occupied.
// Reset clears the count and control; cell contents stay unknown.
`timescale 1ns / 1ps

module positional_array_list_core import pal_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [2:0]        s_action,
    input  logic [POS_W-1:0]  s_position,
    input  logic [DATA_W-1:0] s_value,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [1:0]        m_status,
    output logic [POS_W-1:0]  m_found_position,
    output logic [CNT_W-1:0]  m_count
);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_FIND = 2'b10
    } state_t;

    state_t            state_reg, state_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    status_t           pend_status_reg, pend_status_next;
    logic [CNT_W-1:0]  pend_count_reg, pend_count_next;
    logic              pend_search_reg, pend_search_next;
    logic              m_valid_reg, m_valid_next;
    status_t           m_status_reg, m_status_next;
    logic [CNT_W-1:0]  m_found_reg, m_found_next;
    logic [CNT_W-1:0]  m_count_reg, m_count_next;

    cell_ctrl_t        ctrl;
    status_t           req_status;
    logic              s_xfer;
    logic              out_free;
    logic [DATA_W-1:0] cell_data [DEPTH];
    logic [DEPTH-1:0]  match_vec;
    logic [CNT_W-1:0]  found_pos;
    logic [CNT_W:0]    pos_ext, cnt_ext;

    assign s_ready  = (state_reg == S_IDLE);
    assign s_xfer   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;
    assign pos_ext  = {1'b0, s_position};
    assign cnt_ext  = {1'b0, count_reg};

    always_comb begin
        ctrl.op    = OP_NONE;
        ctrl.at    = '0;
        ctrl.value = s_value;
        ctrl.count = count_reg;
        req_status = ST_OK;
        count_next = count_reg;
        case (action_t'(s_action))
            ACT_PUSH_FRONT, ACT_PUSH_BACK, ACT_INSERT: begin
                if (cnt_ext >= (CNT_W+1)'(DEPTH)) begin
                    req_status = ST_FULL;
                end else if (action_t'(s_action) == ACT_PUSH_FRONT) begin
                    ctrl.op = OP_INS;
                end else if (action_t'(s_action) == ACT_PUSH_BACK) begin
                    ctrl.op = OP_INS;
                    ctrl.at = count_reg[IDX_W-1:0];
                end else if (pos_ext == '0 || pos_ext > cnt_ext + 1'b1) begin
                    req_status = ST_RANGE;
                end else begin
                    ctrl.op = OP_INS;
                    ctrl.at = IDX_W'(s_position - 1'b1);
                end
            end
            ACT_ERASE_FRONT, ACT_ERASE_BACK, ACT_ERASE: begin
                if (count_reg == '0) begin
                    req_status = ST_EMPTY;
                end else if (action_t'(s_action) == ACT_ERASE_FRONT) begin
                    ctrl.op = OP_DEL;
                end else if (action_t'(s_action) == ACT_ERASE_BACK) begin
                    ctrl.op = OP_DEL;
                    ctrl.at = IDX_W'(count_reg - 1'b1);
                end else if (pos_ext == '0 || pos_ext > cnt_ext) begin
                    req_status = ST_RANGE;
                end else begin
                    ctrl.op = OP_DEL;
                    ctrl.at = IDX_W'(s_position - 1'b1);
                end
            end
            ACT_SEARCH: begin
                ctrl.op = OP_FIND;
            end
            default: begin
            end
        endcase
        if (!s_xfer) begin
            ctrl.op = OP_NONE;
        end
        if (ctrl.op == OP_INS) begin
            count_next = count_reg + 1'b1;
        end else if (ctrl.op == OP_DEL) begin
            count_next = count_reg - 1'b1;
        end
    end

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic [DATA_W-1:0] left_d, right_d;
        if (g == 0) begin : g_first
            assign left_d = '0;
        end else begin : g_mid_l
            assign left_d = cell_data[g-1];
        end
        if (g == DEPTH - 1) begin : g_last
            assign right_d = '0;
        end else begin : g_mid_r
            assign right_d = cell_data[g+1];
        end
        pal_cell u_cell (
            .aclk       (aclk),
            .cell_idx   (IDX_W'(g)),
            .ctrl       (ctrl),
            .left_data  (left_d),
            .right_data (right_d),
            .data       (cell_data[g]),
            .match      (match_vec[g])
        );
    end

    pal_prio u_prio (
        .match (match_vec),
        .found (found_pos)
    );

    always_comb begin
        state_next       = state_reg;
        pend_status_next = pend_status_reg;
        pend_count_next  = pend_count_reg;
        pend_search_next = pend_search_reg;
        m_valid_next     = m_valid_reg;
        m_status_next    = m_status_reg;
        m_found_next     = m_found_reg;
        m_count_next     = m_count_reg;
        if (m_ready) begin
            m_valid_next = 1'b0;
        end
        case (state_reg)
            S_IDLE: begin
                if (s_xfer) begin
                    pend_status_next = req_status;
                    pend_count_next  = count_next;
                    pend_search_next = (ctrl.op == OP_FIND);
                    state_next       = S_FIND;
                end
            end
            S_FIND: begin
                if (out_free) begin
                    m_valid_next  = 1'b1;
                    m_status_next = pend_status_reg;
                    m_found_next  = pend_search_reg ? found_pos : '0;
                    m_count_next  = pend_count_reg;
                    state_next    = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        pend_status_reg <= pend_status_next;
        pend_count_reg  <= pend_count_next;
        pend_search_reg <= pend_search_next;
        m_status_reg    <= m_status_next;
        m_found_reg     <= m_found_next;
        m_count_reg     <= m_count_next;
    end

    assign m_valid          = m_valid_reg;
    assign m_status         = m_status_reg;
    assign m_found_position = m_found_reg;
    assign m_count          = m_count_reg;

endmodule

// ===== hw/rtl/positional_array_list_checker.sv =====
// Port-level checker for the positional array list, bound to the top level.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module positional_array_list_checker import pal_pkg::*; (
    input logic              aclk,
    input logic              aresetn,
    input logic              s_valid,
    input logic              s_ready,
    input logic [2:0]        s_action,
    input logic [POS_W-1:0]  s_position,
    input logic [DATA_W-1:0] s_value,
    input logic              m_valid,
    input logic              m_ready,
    input logic [1:0]        m_status,
    input logic [POS_W-1:0]  m_found_position,
    input logic [CNT_W-1:0]  m_count
);

    `PAL_ASSERT_NXT(a_out_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_count))
    `PAL_ASSERT_IMP(a_found_le_count, aclk, aresetn, m_valid, m_found_position <= m_count)
    `PAL_ASSERT_IMP(a_full_count, aclk, aresetn, m_valid && m_status == ST_FULL, m_count == CNT_W'(DEPTH))
    `PAL_ASSERT_IMP(a_empty_count, aclk, aresetn, m_valid && m_status == ST_EMPTY, m_count == '0)
    `PAL_ASSERT_NXT(a_accept_gap, aclk, aresetn, s_valid && s_ready, !s_ready)

endmodule

bind positional_array_list_core positional_array_list_checker u_checker (.*);
